/* hdl/rstc_pkg.sv */
// Shared types, constants and tables for the rotation-scale transform composer.
// Holds the item payloads, the microcode word and program, and the quarter-wave sine ROM.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package rstc_pkg;

   // Fixed-point and table geometry.
   localparam int FRAC_BITS  = 16;
   localparam int TABLE_BITS = 10;
   localparam int TABLE_SIZE = 1 << TABLE_BITS;
   localparam int PHASE_W    = TABLE_BITS + 2;

   // Field and datapath widths.
   localparam int DATA_W    = 32;
   localparam int ANGLE_W   = 16;
   localparam int OP_W      = 2;
   localparam int SIN_W     = 16;
   localparam int TRIG_W    = SIN_W + 1;
   localparam int PROD_W    = 2 * DATA_W;
   localparam int ACC_W     = PROD_W + 1;
   localparam int SHIFT_W   = ACC_W - FRAC_BITS;
   localparam int WB_W      = SHIFT_W + 1;
   localparam int LOC_SHIFT = 15;

   localparam logic [SIN_W-1:0] SIN_MAX = 16'd32767;

   // Constants of the sine table generator (Q30).
   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
   localparam logic [63:0] ONE_Q30     = 64'd1 << 30;

   // Microprogram geometry.
   localparam int STEP_W      = 5;
   localparam int STEP_COUNT  = 23;
   localparam logic [STEP_W-1:0] STEP_POS    = 5'd16;
   localparam logic [STEP_W-1:0] STEP_FINISH = 5'd22;

   // Input and result payloads.
   typedef struct packed {
      logic [OP_W-1:0]           operation;
      logic [ANGLE_W-1:0]        angle;
      logic signed [DATA_W-1:0]  scale_x;
      logic signed [DATA_W-1:0]  scale_y;
      logic signed [DATA_W-1:0]  pos_x;
      logic signed [DATA_W-1:0]  pos_y;
      logic signed [DATA_W-1:0]  parent_m00;
      logic signed [DATA_W-1:0]  parent_m10;
      logic signed [DATA_W-1:0]  parent_m01;
      logic signed [DATA_W-1:0]  parent_m11;
      logic signed [DATA_W-1:0]  parent_px;
      logic signed [DATA_W-1:0]  parent_py;
   } req_item_type;

   typedef struct packed {
      logic signed [DATA_W-1:0]  out_m00;
      logic signed [DATA_W-1:0]  out_m10;
      logic signed [DATA_W-1:0]  out_m01;
      logic signed [DATA_W-1:0]  out_m11;
      logic signed [DATA_W-1:0]  out_px;
      logic signed [DATA_W-1:0]  out_py;
   } rsp_item_type;

   typedef enum logic [OP_W-1:0] {
      OP_FULL     = 2'd0,
      OP_POSITION = 2'd1,
      OP_MATRIX   = 2'd2,
      OP_NONE     = 2'd3
   } op_type;

   typedef enum logic {
      SEQ_IDLE,
      SEQ_RUN
   } seq_state_type;

   // Microcode fields.
   typedef enum logic {
      ROM_SIN,
      ROM_COS
   } rom_sel_type;

   typedef enum logic [2:0] {
      MA_SX,
      MA_SY,
      MA_P00,
      MA_P10,
      MA_P01,
      MA_P11
   } mul_a_type;

   typedef enum logic [3:0] {
      MB_SIN,
      MB_COS,
      MB_NSIN,
      MB_L00,
      MB_L10,
      MB_L01,
      MB_L11,
      MB_LX,
      MB_LY
   } mul_b_type;

   typedef enum logic [1:0] {
      ACC_HOLD,
      ACC_LOAD,
      ACC_ADD_RND
   } acc_op_type;

   typedef enum logic [3:0] {
      DST_NONE,
      DST_L00,
      DST_L10,
      DST_L01,
      DST_L11,
      DST_M00,
      DST_M10,
      DST_M01,
      DST_M11,
      DST_PX,
      DST_PY
   } dest_type;

   typedef enum logic [1:0] {
      COND_NONE,
      COND_NO_MATRIX,
      COND_NO_POS
   } cond_type;

   typedef struct packed {
      rom_sel_type        rom_sel;
      logic               ld_sin;
      logic               ld_cos;
      mul_a_type          mul_a;
      mul_b_type          mul_b;
      acc_op_type         acc_op;
      dest_type           dest;
      cond_type           cond;
      logic [STEP_W-1:0]  target;
      logic               finish;
   } ucode_type;

   localparam ucode_type UC_NOP = '{
      rom_sel: ROM_SIN,
      ld_sin:  1'b0,
      ld_cos:  1'b0,
      mul_a:   MA_SX,
      mul_b:   MB_SIN,
      acc_op:  ACC_HOLD,
      dest:    DST_NONE,
      cond:    COND_NONE,
      target:  '0,
      finish:  1'b0
   };

   // Microprogram. The multiplier product is registered and the accumulator registers it in turn;
   // a sine read passes the ROM output register before it is loaded into the sine or cosine register.
   function automatic ucode_type ucode_word(input logic [STEP_W-1:0] step);
      ucode_type w;
      w = UC_NOP;
      case (step)
         // Sine lookup; items without a matrix update go straight to positions.
         5'd0: begin
            w.rom_sel = ROM_SIN;
            w.cond    = COND_NO_MATRIX;
            w.target  = STEP_POS;
         end
         5'd1: begin
            w.rom_sel = ROM_COS;
            w.ld_sin  = 1'b1;
         end
         // Local rotation-scale matrix.
         5'd2: begin
            w.ld_cos = 1'b1;
            w.mul_a  = MA_SX;
            w.mul_b  = MB_SIN;
         end
         5'd3: begin
            w.mul_a = MA_SX;
            w.mul_b = MB_COS;
            w.dest  = DST_L10;
         end
         5'd4: begin
            w.mul_a = MA_SY;
            w.mul_b = MB_NSIN;
            w.dest  = DST_L00;
         end
         5'd5: begin
            w.mul_a = MA_SY;
            w.mul_b = MB_COS;
            w.dest  = DST_L01;
         end
         // Parent matrix times local matrix.
         5'd6: begin
            w.mul_a = MA_P00;
            w.mul_b = MB_L00;
            w.dest  = DST_L11;
         end
         5'd7: begin
            w.mul_a  = MA_P01;
            w.mul_b  = MB_L10;
            w.acc_op = ACC_LOAD;
         end
         5'd8: begin
            w.mul_a  = MA_P10;
            w.mul_b  = MB_L00;
            w.acc_op = ACC_ADD_RND;
         end
         5'd9: begin
            w.mul_a  = MA_P11;
            w.mul_b  = MB_L10;
            w.acc_op = ACC_LOAD;
            w.dest   = DST_M00;
         end
         5'd10: begin
            w.mul_a  = MA_P00;
            w.mul_b  = MB_L01;
            w.acc_op = ACC_ADD_RND;
         end
         5'd11: begin
            w.mul_a  = MA_P01;
            w.mul_b  = MB_L11;
            w.acc_op = ACC_LOAD;
            w.dest   = DST_M10;
         end
         5'd12: begin
            w.mul_a  = MA_P10;
            w.mul_b  = MB_L01;
            w.acc_op = ACC_ADD_RND;
         end
         5'd13: begin
            w.mul_a  = MA_P11;
            w.mul_b  = MB_L11;
            w.acc_op = ACC_LOAD;
            w.dest   = DST_M01;
         end
         5'd14: begin
            w.acc_op = ACC_ADD_RND;
         end
         5'd15: begin
            w.dest = DST_M11;
         end
         // Position: parent position plus parent matrix times local position.
         5'd16: begin
            w.mul_a  = MA_P00;
            w.mul_b  = MB_LX;
            w.cond   = COND_NO_POS;
            w.target = STEP_FINISH;
         end
         5'd17: begin
            w.mul_a  = MA_P01;
            w.mul_b  = MB_LY;
            w.acc_op = ACC_LOAD;
         end
         5'd18: begin
            w.mul_a  = MA_P10;
            w.mul_b  = MB_LX;
            w.acc_op = ACC_ADD_RND;
         end
         5'd19: begin
            w.mul_a  = MA_P11;
            w.mul_b  = MB_LY;
            w.acc_op = ACC_LOAD;
            w.dest   = DST_PX;
         end
         5'd20: begin
            w.acc_op = ACC_ADD_RND;
         end
         5'd21: begin
            w.dest = DST_PY;
         end
         5'd22: begin
            w.finish = 1'b1;
         end
         default: begin
            w.finish = 1'b1;
         end
      endcase
      return w;
   endfunction

   // Quarter-wave sine table in Q1.15, built at elaboration from a
   // degree-13 Taylor series in Q30 (Horner form, each step truncated).
   typedef logic [SIN_W-1:0] sine_rom_type [TABLE_SIZE];

   function automatic sine_rom_type build_sine_rom();
      sine_rom_type rom;
      logic [63:0]  x;
      logic [63:0]  x2;
      logic [63:0]  t;
      logic [63:0]  s;
      logic [63:0]  q;
      for (int i = 0; i < TABLE_SIZE; i++) begin
         x  = (HALF_PI_Q30 * 64'(i)) >> TABLE_BITS;
         x2 = (x * x) >> 30;
         t  = ONE_Q30;
         t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd156;
         t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd110;
         t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd72;
         t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd42;
         t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd20;
         t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd6;
         s  = (x * t) >> 30;
         q  = (s + 64'd16384) >> 15;
         if (q > 64'(SIN_MAX)) begin
            q = 64'(SIN_MAX);
         end
         rom[i] = q[SIN_W-1:0];
      end
      return rom;
   endfunction

endpackage

`default_nettype wire

/* hdl/rstc_if.sv */
// Valid/ready channel interfaces for the transform composer's item and result beats.
// Depends on rstc_pkg for the payload types.
`default_nettype none

interface rstc_req_if;
   import rstc_pkg::*;

   logic         valid;
   logic         ready;
   req_item_type item;

   modport source (output valid, output item, input ready);
   modport sink   (input valid, input item, output ready);
endinterface

interface rstc_rsp_if;
   import rstc_pkg::*;

   logic         valid;
   logic         ready;
   rsp_item_type item;

   modport source (output valid, output item, input ready);
   modport sink   (input valid, input item, output ready);
endinterface

`default_nettype wire

/* hdl/rotation_scale_transform_compose.sv */
// Top level of the 2D rotation-scale transform composer.
// Depends on rstc_pkg (types, microprogram, sine ROM) and rstc_if (channels).
//
// Usage: each beat on req_ch carries a node's local transform (angle, scale,
// position), its parent's global matrix and position, and an operation code.
// Every request beat yields exactly one result beat on rsp_ch holding the
// stored global matrix and position after the update. Operation full updates
// both, position-only and matrix-only update one part and return the other
// as stored, and the fourth code updates nothing.
// Timing: a microcoded sequencer drives one shared 32x32 multiplier and a
// 65-bit accumulator. A full update reads the sine ROM and then runs the
// sixteen multiplier passes; position-only and matrix-only updates skip the
// steps of the part they leave alone, and the fourth code skips both. A new
// request is taken only once the sequencer has handed its result to the
// output register, so one item is never started before the last is done.
// Reset: synchronous; the stored matrix returns to identity, the stored
// position to zero, and no result is pending. The sine ROM is constant.
// Stall: the result waits in an output register; a following request is
// accepted and processed, and the sequencer holds on its last step until
// the output register is free.
`default_nettype none

module rotation_scale_transform_compose (
   input  wire logic clock,
   input  wire logic reset,
   rstc_req_if.sink   req_ch,
   rstc_rsp_if.source rsp_ch
);
   import rstc_pkg::*;

   localparam sine_rom_type SINE_ROM = build_sine_rom();

   localparam logic signed [ACC_W-1:0]  ROUND_HALF = ACC_W'(1) << (FRAC_BITS - 1);
   localparam logic signed [PROD_W-1:0] LOC_HALF   = PROD_W'(1) << (LOC_SHIFT - 1);
   localparam logic signed [WB_W-1:0]   SAT_HI     = WB_W'(32'sh7FFF_FFFF);
   localparam logic signed [WB_W-1:0]   SAT_LO     = WB_W'($signed(32'h8000_0000));
   localparam logic signed [DATA_W-1:0] ONE_FIX    = DATA_W'(1) << FRAC_BITS;

   // Sequencer state.
   seq_state_type      state_ff;
   seq_state_type      state_in;
   logic [STEP_W-1:0]  step_ff;
   logic [STEP_W-1:0]  step_in;
   ucode_type          uw;
   logic               load_rsp;
   logic               take_jump;
   logic               running;
   logic               req_take;

   // Captured item and decoded operation.
   req_item_type       item_ff;
   op_type             op;
   logic               do_matrix;
   logic               do_pos;

   // Sine lookup.
   logic [PHASE_W-1:0]     phase;
   logic [PHASE_W-1:0]     rd_phase;
   logic [1:0]             quad;
   logic [TABLE_BITS-1:0]  rd_off;
   logic [TABLE_BITS-1:0]  rd_addr;
   logic [SIN_W-1:0]       rom_q_ff;
   logic                   rom_peak_ff;
   logic                   rom_neg_ff;
   logic [SIN_W-1:0]       trig_mag;
   logic signed [TRIG_W-1:0] trig_pos;
   logic signed [TRIG_W-1:0] trig_val;
   logic signed [TRIG_W-1:0] sin_ff;
   logic signed [TRIG_W-1:0] cos_ff;
   logic signed [TRIG_W-1:0] nsin;

   // Multiply-accumulate datapath.
   logic signed [DATA_W-1:0]  op_a;
   logic signed [DATA_W-1:0]  op_b;
   logic signed [PROD_W-1:0]  prod_ff;
   logic signed [ACC_W-1:0]   acc_ff;
   logic signed [PROD_W-1:0]  loc_round;
   logic signed [DATA_W-1:0]  loc_val;
   logic signed [SHIFT_W-1:0] acc_shift;
   logic signed [DATA_W-1:0]  addend;
   logic signed [WB_W-1:0]    wb_sum;
   logic signed [DATA_W-1:0]  wb_sat;

   // Local matrix (l00, l10, l01, l11) and stored global transform.
   logic signed [DATA_W-1:0]  local_ff  [4];
   logic signed [DATA_W-1:0]  held_m_ff [4];
   logic signed [DATA_W-1:0]  held_p_ff [2];

   // Output register.
   logic                      rsp_valid_ff;
   rsp_item_type              rsp_item_ff;

   // Control word of the current step.
   assign uw      = ucode_word(step_ff);
   assign running = (state_ff == SEQ_RUN);
   assign req_take = req_ch.valid && req_ch.ready;

   assign op        = op_type'(item_ff.operation);
   assign do_matrix = (op == OP_FULL) || (op == OP_MATRIX);
   assign do_pos    = (op == OP_FULL) || (op == OP_POSITION);

   // Conditional jump decode.
   always_comb begin
      unique case (uw.cond)
         COND_NO_MATRIX: take_jump = !do_matrix;
         COND_NO_POS:    take_jump = !do_pos;
         default:        take_jump = 1'b0;
      endcase
   end

   // Sequencer: next state, next step and output hand-off.
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      load_rsp = 1'b0;
      unique case (state_ff)
         SEQ_IDLE: begin
            if (req_ch.valid) begin
               state_in = SEQ_RUN;
               step_in  = '0;
            end
         end
         SEQ_RUN: begin
            if (uw.finish) begin
               if (!rsp_valid_ff || rsp_ch.ready) begin
                  load_rsp = 1'b1;
                  state_in = SEQ_IDLE;
               end
            end else if (take_jump) begin
               step_in = uw.target;
            end else begin
               step_in = step_ff + STEP_W'(1);
            end
         end
         default: begin
            state_in = SEQ_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SEQ_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   assign req_ch.ready = (state_ff == SEQ_IDLE);

   // Capture the request beat.
   always_ff @(posedge clock) begin
      if (req_take) begin
         item_ff <= req_ch.item;
      end
   end

   // Sine ROM address: mirror odd quadrants, flag the peak and the sign.
   assign phase    = item_ff.angle[ANGLE_W-1 -: PHASE_W];
   assign rd_phase = (uw.rom_sel == ROM_COS) ? phase + PHASE_W'(TABLE_SIZE) : phase;
   assign quad     = rd_phase[PHASE_W-1 -: 2];
   assign rd_off   = rd_phase[TABLE_BITS-1:0];
   assign rd_addr  = quad[0] ? TABLE_BITS'(0) - rd_off : rd_off;

   always_ff @(posedge clock) begin
      rom_q_ff    <= SINE_ROM[rd_addr];
      rom_peak_ff <= quad[0] && (rd_off == '0);
      rom_neg_ff  <= quad[1];
   end

   assign trig_mag = rom_peak_ff ? SIN_MAX : rom_q_ff;
   assign trig_pos = signed'({1'b0, trig_mag});
   assign trig_val = rom_neg_ff ? -trig_pos : trig_pos;
   assign nsin     = -sin_ff;

   always_ff @(posedge clock) begin
      if (running && uw.ld_sin) begin
         sin_ff <= trig_val;
      end
      if (running && uw.ld_cos) begin
         cos_ff <= trig_val;
      end
   end

   // Multiplier operand selection.
   always_comb begin
      unique case (uw.mul_a)
         MA_SX:   op_a = item_ff.scale_x;
         MA_SY:   op_a = item_ff.scale_y;
         MA_P00:  op_a = item_ff.parent_m00;
         MA_P10:  op_a = item_ff.parent_m10;
         MA_P01:  op_a = item_ff.parent_m01;
         MA_P11:  op_a = item_ff.parent_m11;
         default: op_a = '0;
      endcase
   end

   always_comb begin
      unique case (uw.mul_b)
         MB_SIN:  op_b = DATA_W'(sin_ff);
         MB_COS:  op_b = DATA_W'(cos_ff);
         MB_NSIN: op_b = DATA_W'(nsin);
         MB_L00:  op_b = local_ff[0];
         MB_L10:  op_b = local_ff[1];
         MB_L01:  op_b = local_ff[2];
         MB_L11:  op_b = local_ff[3];
         MB_LX:   op_b = item_ff.pos_x;
         MB_LY:   op_b = item_ff.pos_y;
         default: op_b = '0;
      endcase
   end

   // Shared multiplier, registered.
   always_ff @(posedge clock) begin
      prod_ff <= op_a * op_b;
   end

   // Accumulator: the second product of a pair also adds the rounding half.
   always_ff @(posedge clock) begin
      if (running) begin
         case (uw.acc_op)
            ACC_LOAD:    acc_ff <= ACC_W'(prod_ff);
            ACC_ADD_RND: acc_ff <= acc_ff + ACC_W'(prod_ff) + ROUND_HALF;
            default:     acc_ff <= acc_ff;
         endcase
      end
   end

   // Local entry: Q1.15 product rounded half up.
   assign loc_round = prod_ff + LOC_HALF;
   assign loc_val   = loc_round[LOC_SHIFT +: DATA_W];

   // Global entry: drop the fraction, add the parent position to a position entry, saturate.
   assign acc_shift = acc_ff[ACC_W-1:FRAC_BITS];

   always_comb begin
      unique case (uw.dest)
         DST_PX:  addend = item_ff.parent_px;
         DST_PY:  addend = item_ff.parent_py;
         default: addend = '0;
      endcase
   end

   assign wb_sum = WB_W'(acc_shift) + WB_W'(addend);

   always_comb begin
      if (wb_sum > SAT_HI) begin
         wb_sat = SAT_HI[DATA_W-1:0];
      end else if (wb_sum < SAT_LO) begin
         wb_sat = SAT_LO[DATA_W-1:0];
      end else begin
         wb_sat = wb_sum[DATA_W-1:0];
      end
   end

   // Write-back of local entries (payload, no reset).
   always_ff @(posedge clock) begin
      if (running) begin
         case (uw.dest)
            DST_L00: local_ff[0] <= loc_val;
            DST_L10: local_ff[1] <= loc_val;
            DST_L01: local_ff[2] <= loc_val;
            DST_L11: local_ff[3] <= loc_val;
            default: ;
         endcase
      end
   end

   // Write-back of the stored global transform.
   always_ff @(posedge clock) begin
      if (reset) begin
         held_m_ff[0] <= ONE_FIX;
         held_m_ff[1] <= '0;
         held_m_ff[2] <= '0;
         held_m_ff[3] <= ONE_FIX;
         held_p_ff[0] <= '0;
         held_p_ff[1] <= '0;
      end else if (running) begin
         case (uw.dest)
            DST_M00: held_m_ff[0] <= wb_sat;
            DST_M10: held_m_ff[1] <= wb_sat;
            DST_M01: held_m_ff[2] <= wb_sat;
            DST_M11: held_m_ff[3] <= wb_sat;
            DST_PX:  held_p_ff[0] <= wb_sat;
            DST_PY:  held_p_ff[1] <= wb_sat;
            default: ;
         endcase
      end
   end

   // Output register: a result beat stays until taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_item_ff.out_m00 <= held_m_ff[0];
         rsp_item_ff.out_m10 <= held_m_ff[1];
         rsp_item_ff.out_m01 <= held_m_ff[2];
         rsp_item_ff.out_m11 <= held_m_ff[3];
         rsp_item_ff.out_px  <= held_p_ff[0];
         rsp_item_ff.out_py  <= held_p_ff[1];
      end
   end

   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.item  = rsp_item_ff;

   // An accepted beat starts the program at its first step.
   a_start_at_zero: assert property (@(posedge clock) disable iff (reset)
      req_take |=> (state_ff == SEQ_RUN) && (step_ff == '0))
      else $error("sequencer did not start at step zero after a request beat");

   // A position-only item leaves the stored matrix untouched.
   a_pos_keeps_matrix: assert property (@(posedge clock) disable iff (reset)
      (running && (op == OP_POSITION))
      |=> $stable({held_m_ff[0], held_m_ff[1], held_m_ff[2], held_m_ff[3]}))
      else $error("stored matrix changed during a position-only update");

   // Handing off a result frees the sequencer and offers the beat.
   a_handoff: assert property (@(posedge clock) disable iff (reset)
      load_rsp |=> rsp_ch.valid && (state_ff == SEQ_IDLE))
      else $error("result hand-off did not raise valid and idle the sequencer");

   // The step counter never leaves the program.
   a_step_range: assert property (@(posedge clock) disable iff (reset)
      running |-> (step_ff < STEP_W'(STEP_COUNT)))
      else $error("step counter ran past the end of the microprogram");

endmodule

`default_nettype wire

/* test/rstc_checker.sv */
// Scoreboard for the rotation-scale transform composer: watches both channels,
// predicts every result beat from the accepted request beats, and compares them.
// Depends on rstc_pkg (payload types, op codes, table geometry) and rstc_if.

module rstc_checker (
   input  wire logic clock,
   input  wire logic reset,
   rstc_req_if       req_ch,
   rstc_rsp_if       rsp_ch,
   output int        fail_count,
   output int        pending_count
);
   import rstc_pkg::*;

   // Wide enough for the sum of two full 64-bit products without overflow.
   typedef logic signed [79:0] wide_type;

   localparam wide_type S32_MAX = 80'sh7FFF_FFFF;
   localparam wide_type S32_MIN = -80'sh8000_0000;

   int                       quarter_sine [TABLE_SIZE];
   rsp_item_type             pending_transforms [$];
   logic signed [DATA_W-1:0] held_m00, held_m10, held_m01, held_m11;
   logic signed [DATA_W-1:0] held_px, held_py;
   rsp_item_type             want;
   int                       mismatches;

   // Quarter-wave sine in Q1.15, from a Taylor series in Q30 evaluated in
   // Horner form. The divisors are n*(n-1) for n = 13, 11, ..., 3.
   initial begin
      bit [63:0] x, x2, t, s, q;
      for (int i = 0; i < TABLE_SIZE; i++) begin
         x  = (HALF_PI_Q30 * 64'(i)) >> TABLE_BITS;
         x2 = (x * x) >> 30;
         t  = ONE_Q30;
         for (int n = 13; n >= 3; n -= 2) begin
            t = ONE_Q30 - ((x2 * t) >> 30) / 64'(n * (n - 1));
         end
         s = (x * t) >> 30;
         q = (s + 64'd16384) >> 15;
         if (q > 64'(SIN_MAX)) begin
            q = 64'(SIN_MAX);
         end
         quarter_sine[i] = int'(q);
      end
   end

   function automatic logic signed [DATA_W-1:0] clamp32(input wide_type v);
      if (v > S32_MAX) begin
         return S32_MAX[DATA_W-1:0];
      end
      if (v < S32_MIN) begin
         return S32_MIN[DATA_W-1:0];
      end
      return v[DATA_W-1:0];
   endfunction

   // Signed sine of a table phase; quadrants mirror the quarter wave, and the
   // peak of an odd quadrant reads as full scale.
   function automatic int trig_at(input int phase);
      int quad, r, mag;
      quad = (phase >> TABLE_BITS) & 3;
      r    = phase & (TABLE_SIZE - 1);
      if (quad & 1) begin
         mag = (r == 0) ? int'(SIN_MAX) : quarter_sine[(TABLE_SIZE - r) & (TABLE_SIZE - 1)];
      end else begin
         mag = quarter_sine[r];
      end
      return (quad & 2) ? -mag : mag;
   endfunction

   // Value times a Q1.15 factor, rounded half up.
   function automatic wide_type scale_trig(input wide_type v, input int f);
      return (v * wide_type'(f) + (wide_type'(1) <<< 14)) >>> LOC_SHIFT;
   endfunction

   // Rounded Q16.16 dot product of two pairs.
   function automatic wide_type dot_round(input wide_type a, b, c, d);
      return (a * b + c * d + (wide_type'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
   endfunction

   // Applies one request to the held transform and returns what is then held.
   function automatic rsp_item_type compose_transform(input req_item_type it);
      op_type       op;
      int           phase, sn, cs;
      wide_type     l00, l10, l01, l11;
      rsp_item_type r;
      op    = op_type'(it.operation);
      phase = int'(it.angle) >> (14 - TABLE_BITS);
      if (op == OP_FULL || op == OP_MATRIX) begin
         sn  = trig_at(phase);
         cs  = trig_at(phase + TABLE_SIZE);
         l00 = scale_trig($signed(it.scale_x), cs);
         l10 = scale_trig($signed(it.scale_x), sn);
         l01 = scale_trig($signed(it.scale_y), -sn);
         l11 = scale_trig($signed(it.scale_y), cs);
         held_m00 = clamp32(dot_round($signed(it.parent_m00), l00, $signed(it.parent_m01), l10));
         held_m10 = clamp32(dot_round($signed(it.parent_m10), l00, $signed(it.parent_m11), l10));
         held_m01 = clamp32(dot_round($signed(it.parent_m00), l01, $signed(it.parent_m01), l11));
         held_m11 = clamp32(dot_round($signed(it.parent_m10), l01, $signed(it.parent_m11), l11));
      end
      if (op == OP_FULL || op == OP_POSITION) begin
         held_px = clamp32(wide_type'($signed(it.parent_px)) +
                           dot_round($signed(it.parent_m00), $signed(it.pos_x),
                                     $signed(it.parent_m01), $signed(it.pos_y)));
         held_py = clamp32(wide_type'($signed(it.parent_py)) +
                           dot_round($signed(it.parent_m10), $signed(it.pos_x),
                                     $signed(it.parent_m11), $signed(it.pos_y)));
      end
      r.out_m00 = held_m00;
      r.out_m10 = held_m10;
      r.out_m01 = held_m01;
      r.out_m11 = held_m11;
      r.out_px  = held_px;
      r.out_py  = held_py;
      return r;
   endfunction

   function automatic int field_differs(input string field, input logic [DATA_W-1:0] exp_v,
                                        input logic [DATA_W-1:0] got_v);
      if (exp_v !== got_v) begin
         $error("%s: expected %0d, got %0d", field, $signed(exp_v), $signed(got_v));
         return 1;
      end
      return 0;
   endfunction

   // Result beats are checked before the request beat of the same edge is
   // predicted, since no result can follow its request that closely.
   always @(posedge clock) begin
      if (reset) begin
         held_m00 = 32'(1) << FRAC_BITS;
         held_m10 = '0;
         held_m01 = '0;
         held_m11 = 32'(1) << FRAC_BITS;
         held_px  = '0;
         held_py  = '0;
         pending_transforms.delete();
         mismatches = 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (pending_transforms.size() == 0) begin
               $error("result beat arrived with no request outstanding");
               mismatches++;
            end else begin
               want = pending_transforms.pop_front();
               mismatches += field_differs("out_m00", want.out_m00, rsp_ch.item.out_m00);
               mismatches += field_differs("out_m10", want.out_m10, rsp_ch.item.out_m10);
               mismatches += field_differs("out_m01", want.out_m01, rsp_ch.item.out_m01);
               mismatches += field_differs("out_m11", want.out_m11, rsp_ch.item.out_m11);
               mismatches += field_differs("out_px", want.out_px, rsp_ch.item.out_px);
               mismatches += field_differs("out_py", want.out_py, rsp_ch.item.out_py);
            end
         end
         if (req_ch.valid && req_ch.ready) begin
            pending_transforms.push_back(compose_transform(req_ch.item));
         end
      end
      fail_count    <= mismatches;
      pending_count <= pending_transforms.size();
   end

endmodule

/* test/tb.sv */
// Testbench top for the rotation-scale transform composer: clock, reset, request
// and result traffic with random pacing, and the final verdict.
// Depends on rstc_pkg, rstc_if, the block itself and rstc_checker.

module tb;
   import rstc_pkg::*;

   localparam int RANDOM_ITEMS = 1630;

   localparam logic [DATA_W-1:0] Q_ONE = 32'(1) << FRAC_BITS;
   localparam logic [DATA_W-1:0] Q_NEG = -(32'(1) << FRAC_BITS);
   localparam logic [DATA_W-1:0] S_MAX = 32'h7FFF_FFFF;
   localparam logic [DATA_W-1:0] S_MIN = 32'h8000_0000;
   localparam logic [DATA_W-1:0] ONES  = 32'hFFFF_FFFF;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   fail_count;
   int   pending_count;
   int   burst_left = 0;

   rstc_req_if req_ch ();
   rstc_rsp_if rsp_ch ();

   rotation_scale_transform_compose DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   rstc_checker compose_check (
      .clock         (clock),
      .reset         (reset),
      .req_ch        (req_ch),
      .rsp_ch        (rsp_ch),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   always #5 clock = ~clock;

   // Run limit, well above the slowest legal run.
   initial begin
      #5_000_000;
      $display("tb: done, errors");
      $finish;
   end

   function automatic req_item_type make_item(
      input op_type op, input logic [ANGLE_W-1:0] angle,
      input logic [DATA_W-1:0] sx, sy, lx, ly, p00, p10, p01, p11, ppx, ppy);
      req_item_type it;
      it.operation  = op;
      it.angle      = angle;
      it.scale_x    = sx;
      it.scale_y    = sy;
      it.pos_x      = lx;
      it.pos_y      = ly;
      it.parent_m00 = p00;
      it.parent_m10 = p10;
      it.parent_m01 = p01;
      it.parent_m11 = p11;
      it.parent_px  = ppx;
      it.parent_py  = ppy;
      return it;
   endfunction

   // Style 0 is any 32-bit value, 1 a moderate Q16.16 value within +/-16.0,
   // anything else one of the corner values.
   function automatic logic [DATA_W-1:0] draw_value(input int style);
      case (style)
         0: begin
            return $urandom;
         end
         1: begin
            return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
         end
         default: begin
            case ($urandom_range(0, 5))
               0: return S_MIN;
               1: return S_MAX;
               2: return '0;
               3: return ONES;
               4: return Q_ONE;
               default: return Q_NEG;
            endcase
         end
      endcase
   endfunction

   // Mostly moderate transforms that compose without saturating, with a share
   // of root nodes, fully random beats and corner-heavy beats.
   function automatic req_item_type random_item();
      req_item_type      it;
      int                mix, pick;
      logic [DATA_W-1:0] f [10];
      mix  = $urandom_range(0, 9);
      pick = $urandom_range(0, 9);
      for (int k = 0; k < 10; k++) begin
         f[k] = draw_value(mix < 6 ? 1 : mix < 8 ? 0 : $urandom_range(0, 2));
      end
      it = make_item((pick < 5) ? OP_FULL : (pick < 7) ? OP_POSITION :
                     (pick < 9) ? OP_MATRIX : OP_NONE,
                     ANGLE_W'($urandom_range(0, 65535)),
                     f[0], f[1], f[2], f[3], f[4], f[5], f[6], f[7], f[8], f[9]);
      if (mix == 4 || mix == 5) begin
         it.parent_m00 = Q_ONE;
         it.parent_m10 = '0;
         it.parent_m01 = '0;
         it.parent_m11 = Q_ONE;
         it.parent_px  = '0;
         it.parent_py  = '0;
      end
      return it;
   endfunction

   // Offers one beat and returns at the edge that accepts it. Beats go out in
   // bursts; between most bursts valid drops for a random gap.
   task automatic send_item(input req_item_type it);
      int gap;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 40);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
         if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_ch.item  <= it;
      req_ch.valid <= 1'b1;
      @(posedge clock);
      while (!req_ch.ready) begin
         @(posedge clock);
      end
   endtask

   // Result side: stretches of always ready, coin flips, mostly stalled and a
   // fixed pattern, plus two long hold-offs that back the block up.
   initial begin
      int mode, span, cycle;
      rsp_ch.ready <= 1'b0;
      cycle = 0;
      while (reset) begin
         @(posedge clock);
      end
      forever begin
         span = $urandom_range(10, 150);
         mode = $urandom_range(0, 3);
         repeat (span) begin
            cycle++;
            if (cycle == 2000 || cycle == 30000) begin
               rsp_ch.ready <= 1'b0;
               repeat (400) @(posedge clock);
               cycle += 400;
            end
            case (mode)
               0: rsp_ch.ready <= 1'b1;
               1: rsp_ch.ready <= 1'($urandom_range(0, 1));
               2: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
               default: rsp_ch.ready <= (cycle % 3 != 0);
            endcase
            @(posedge clock);
         end
      end
   end

   // Stimulus and verdict.
   initial begin
      req_ch.valid <= 1'b0;
      req_ch.item  <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // The held transform right after reset.
      send_item(make_item(OP_NONE, 16'h0000, '0, '0, '0, '0, '0, '0, '0, '0, '0, '0));
      // Root nodes at the quadrant boundaries and around the table ends.
      send_item(make_item(OP_FULL, 16'h0000, Q_ONE, Q_ONE, Q_ONE, 32'hFFFE_0000,
                          Q_ONE, '0, '0, Q_ONE, '0, '0));
      send_item(make_item(OP_FULL, 16'h4000, 32'h0002_0000, 32'h0003_0000, Q_ONE, Q_ONE,
                          Q_ONE, '0, '0, Q_ONE, 32'h0005_0000, 32'hFFFB_0000));
      send_item(make_item(OP_FULL, 16'h8000, Q_ONE, 32'h0000_8000, Q_NEG, Q_ONE,
                          Q_ONE, '0, '0, Q_ONE, '0, '0));
      send_item(make_item(OP_FULL, 16'hC000, Q_ONE, Q_ONE, Q_ONE, Q_ONE,
                          Q_ONE, '0, '0, Q_ONE, '0, '0));
      send_item(make_item(OP_FULL, 16'hFFFF, Q_ONE, Q_ONE, Q_ONE, Q_ONE,
                          Q_ONE, '0, '0, Q_ONE, '0, '0));
      send_item(make_item(OP_FULL, 16'h000F, Q_ONE, Q_ONE, Q_ONE, Q_ONE,
                          Q_ONE, '0, '0, Q_ONE, '0, '0));
      send_item(make_item(OP_FULL, 16'h3FF0, Q_ONE, Q_ONE, Q_ONE, Q_ONE,
                          Q_ONE, '0, '0, Q_ONE, '0, '0));
      // Partial updates under a quarter-turn parent; the other part stays put.
      send_item(make_item(OP_MATRIX, 16'h2000, Q_ONE, 32'h0002_0000, S_MAX, S_MIN,
                          '0, Q_ONE, Q_NEG, '0, S_MAX, S_MIN));
      send_item(make_item(OP_POSITION, 16'h2000, S_MAX, S_MIN, 32'h0003_0000, 32'h0004_0000,
                          '0, Q_ONE, Q_NEG, '0, Q_ONE, Q_ONE));
      send_item(make_item(OP_NONE, 16'h1234, Q_ONE, Q_ONE, Q_ONE, Q_ONE,
                          Q_ONE, Q_ONE, Q_ONE, Q_ONE, Q_ONE, Q_ONE));
      // Position saturating high on x and low on y.
      send_item(make_item(OP_POSITION, 16'h0000, Q_ONE, Q_ONE, Q_ONE, Q_NEG,
                          Q_ONE, '0, '0, Q_ONE, S_MAX, S_MIN));
      // Both products at their largest: the sum leaves the 64-bit range.
      send_item(make_item(OP_POSITION, 16'h0000, Q_ONE, Q_ONE, S_MIN, S_MIN,
                          S_MIN, S_MIN, S_MIN, S_MIN, S_MAX, S_MAX));
      // Matrix saturation at the high bound.
      send_item(make_item(OP_MATRIX, 16'h2000, S_MAX, S_MAX, '0, '0,
                          S_MAX, S_MAX, S_MAX, S_MAX, '0, '0));
      send_item(make_item(OP_MATRIX, 16'h4000, S_MIN, S_MAX, '0, '0,
                          S_MIN, S_MIN, S_MIN, S_MIN, '0, '0));
      send_item(make_item(OP_FULL, 16'h0000, S_MIN, S_MIN, S_MIN, S_MAX,
                          Q_ONE, '0, '0, Q_ONE, '0, '0));
      // Zero scale, all-ones beats, and a mixed-extreme parent.
      send_item(make_item(OP_FULL, 16'h0000, '0, '0, '0, '0, '0, '0, '0, '0, '0, '0));
      send_item(make_item(OP_NONE, 16'hFFFF, ONES, ONES, ONES, ONES,
                          ONES, ONES, ONES, ONES, ONES, ONES));
      send_item(make_item(OP_FULL, 16'hFFFF, ONES, ONES, ONES, ONES,
                          ONES, ONES, ONES, ONES, ONES, ONES));
      send_item(make_item(OP_FULL, 16'h6000, Q_ONE, Q_NEG, S_MAX, S_MIN,
                          S_MAX, S_MIN, S_MIN, S_MAX, S_MAX, S_MIN));

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         send_item(random_item());
      end
      req_ch.valid <= 1'b0;

      // Drain, then keep watching for any stray beat before the verdict.
      @(posedge clock);
      while (pending_count != 0) begin
         @(posedge clock);
      end
      repeat (30) @(posedge clock);
      if (fail_count == 0 && pending_count == 0) begin
         $display("tb: done, clean");
      end else begin
         $display("tb: done, errors");
      end
      $finish;
   end

endmodule
